@@ rtl/offline_rect_add_rect_sum_top_defines.svh @@
// Assertion macros for the rectangle-sum block.
// Used by offline_rect_add_rect_sum_top; no other dependencies.
`ifndef OFFLINE_RECT_ADD_RECT_SUM_TOP_DEFINES_SVH
`define OFFLINE_RECT_ADD_RECT_SUM_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ORS_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define ORS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/ors_pkg.sv @@
// Package for the rectangle-sum block: sizes, command codes, states.
// No dependencies.
package ors_pkg;

    localparam int MAX_RECTS_DEF   = 64;
    localparam int MAX_QUERIES_DEF = 64;
    localparam int COORD_BITS_DEF  = 32;
    localparam int SUM_BITS_DEF    = 64;

    localparam int CMD_W    = 2;
    localparam int FIELD_W  = 32;
    localparam int WEIGHT_W = 64;
    localparam int QIDX_W   = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QREAD,
        ST_RREAD,
        ST_OVL,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/ors_if.sv @@
// Valid/ready channel interfaces for the rectangle-sum block.
// Depends on ors_pkg.
interface ors_in_if
    import ors_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic signed [FIELD_W-1:0]  x_low;
    logic signed [FIELD_W-1:0]  x_high;
    logic signed [FIELD_W-1:0]  y_low;
    logic signed [FIELD_W-1:0]  y_high;
    logic signed [WEIGHT_W-1:0] weight;
    modport source (output valid, command, x_low, x_high, y_low, y_high, weight,
                    input ready);
    modport sink (input valid, command, x_low, x_high, y_low, y_high, weight,
                  output ready);
endinterface

interface ors_out_if
    import ors_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [QIDX_W-1:0]          query_index;
    logic signed [WEIGHT_W-1:0] sum;
    logic                       last;
    logic                       overflow;
    modport source (output valid, query_index, sum, last, overflow, input ready);
    modport sink (input valid, query_index, sum, last, overflow, output ready);
endinterface

@@ rtl/ors_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ors_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/offline_rect_add_rect_sum_top.sv @@
// Offline rectangle add / rectangle sum. Add and query transactions are stored
// as they are accepted. A run walks every query against every stored rectangle
// through one shared overlap datapath and one shared 32x32 multiplier: per
// query a read step, then six steps per rectangle (read, overlap, overlap
// product, weight low product, first cross product, second cross product with
// accumulate), then an output transaction that the receiver may stall.
// The input is not ready during a run. Results come in query order, last marked.
`include "offline_rect_add_rect_sum_top_defines.svh"

module offline_rect_add_rect_sum_top
    import ors_pkg::*;
#(
    parameter int MAX_RECTS   = MAX_RECTS_DEF,
    parameter int MAX_QUERIES = MAX_QUERIES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ors_in_if.sink    in_ch,
    ors_out_if.source out_ch
);
    localparam int RA_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int QA_W = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
    localparam int RC_W = $clog2(MAX_RECTS + 1);
    localparam int QC_W = $clog2(MAX_QUERIES + 1);
    localparam int CW   = COORD_BITS;
    localparam int OW   = COORD_BITS + 1;   // overlap length width
    localparam int EW   = 4 * CW;           // packed edges
    localparam int MW   = 32;               // multiplier operand width

    state_t state_reg, state_next;
    logic [RC_W-1:0] rect_count_reg, rect_count_next;
    logic [QC_W-1:0] query_count_reg, query_count_next;
    logic dropped_reg, dropped_next;
    logic [RC_W-1:0] ri_reg, ri_next;
    logic [QC_W-1:0] qi_reg, qi_next;
    logic [SUM_BITS-1:0] acc_reg, acc_next;
    logic [OW-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic [SUM_BITS-1:0] prod_reg, prod_next;
    logic [EW-1:0] q_reg, q_next;
    logic [MW-1:0] cross_reg, cross_next;

    // Field trimming to the coordinate width
    logic signed [CW-1:0] x0, x1, y0, y1;
    assign x0 = in_ch.x_low[CW-1:0];
    assign x1 = in_ch.x_high[CW-1:0];
    assign y0 = in_ch.y_low[CW-1:0];
    assign y1 = in_ch.y_high[CW-1:0];

    logic in_fire, bad_bounds;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign bad_bounds = (x0 > x1) || (y0 > y1);

    logic rect_we, query_we;
    assign rect_we = in_fire && (in_ch.command == CMD_ADD) && !bad_bounds
                     && (rect_count_reg < RC_W'(MAX_RECTS));
    assign query_we = in_fire && (in_ch.command == CMD_QUERY) && !bad_bounds
                      && (query_count_reg < QC_W'(MAX_QUERIES));

    // Storage; query read address follows qi_next so QREAD sees fresh data
    logic [EW-1:0] edges_in, r_edges, q_edges;
    logic [SUM_BITS-1:0] r_weight;
    assign edges_in = {y1, y0, x1, x0};

    ors_ram #(.WIDTH(EW), .DEPTH(MAX_RECTS)) u_rect_edges (
        .clk(clk), .we(rect_we), .waddr(rect_count_reg[RA_W-1:0]),
        .wdata(edges_in), .raddr(ri_reg[RA_W-1:0]), .rdata(r_edges));
    ors_ram #(.WIDTH(SUM_BITS), .DEPTH(MAX_RECTS)) u_rect_weight (
        .clk(clk), .we(rect_we), .waddr(rect_count_reg[RA_W-1:0]),
        .wdata(in_ch.weight[SUM_BITS-1:0]), .raddr(ri_reg[RA_W-1:0]),
        .rdata(r_weight));
    ors_ram #(.WIDTH(EW), .DEPTH(MAX_QUERIES)) u_query_edges (
        .clk(clk), .we(query_we), .waddr(query_count_reg[QA_W-1:0]),
        .wdata(edges_in), .raddr(qi_next[QA_W-1:0]), .rdata(q_edges));

    // Shared overlap unit: one axis pair from rectangle and query edges
    function automatic logic [OW-1:0] ovl(logic signed [CW-1:0] a0, logic signed [CW-1:0] a1,
                                          logic signed [CW-1:0] b0, logic signed [CW-1:0] b1);
        logic signed [CW-1:0] lo, hi;
        logic signed [OW-1:0] d;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        d = OW'(hi) - OW'(lo);
        return (hi > lo) ? OW'(d) : '0;
    endfunction

    // Shared 32x32 multiplier; the low SUM_BITS of prod * weight are built
    // from the low product and two cross products in MUL2, MUL3 and MUL4
    logic [2*MW-1:0] prod_w, wt_w, mul_p;
    logic [MW-1:0] mul_a, mul_b, cross_sum;
    assign prod_w    = (2*MW)'(prod_reg);
    assign wt_w      = (2*MW)'(r_weight);
    assign mul_p     = (2*MW)'(mul_a) * (2*MW)'(mul_b);
    assign cross_sum = cross_reg + mul_p[MW-1:0];

    // Multiplier operand select
    always_comb
    begin
        mul_a = MW'(ox_reg);
        mul_b = MW'(oy_reg);
        unique case (state_reg)
            ST_MUL2:
            begin
                mul_a = prod_w[MW-1:0];
                mul_b = wt_w[MW-1:0];
            end
            ST_MUL3:
            begin
                mul_a = prod_w[MW-1:0];
                mul_b = wt_w[2*MW-1:MW];
            end
            ST_MUL4:
            begin
                mul_a = prod_w[2*MW-1:MW];
                mul_b = wt_w[MW-1:0];
            end
            default:
            begin
                mul_a = MW'(ox_reg);
                mul_b = MW'(oy_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rect_count_reg  <= '0;
            query_count_reg <= '0;
            dropped_reg     <= 1'b0;
            ri_reg          <= '0;
            qi_reg          <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rect_count_reg  <= rect_count_next;
            query_count_reg <= query_count_next;
            dropped_reg     <= dropped_next;
            ri_reg          <= ri_next;
            qi_reg          <= qi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        prod_reg  <= prod_next;
        q_reg     <= q_next;
        cross_reg <= cross_next;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        rect_count_next  = rect_count_reg;
        query_count_next = query_count_reg;
        dropped_next     = dropped_reg;
        ri_next          = ri_reg;
        qi_next          = qi_reg;
        acc_next         = acc_reg;
        ox_next          = ox_reg;
        oy_next          = oy_reg;
        prod_next        = prod_reg;
        q_next           = q_reg;
        cross_next       = cross_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_ch.command)
                        CMD_ADD:
                        begin
                            if (rect_we) rect_count_next = rect_count_reg + 1'b1;
                            else dropped_next = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            if (query_we) query_count_next = query_count_reg + 1'b1;
                            else dropped_next = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            rect_count_next  = '0;
                            query_count_next = '0;
                            dropped_next     = 1'b0;
                        end
                        default:
                        begin
                            qi_next = '0;
                            if (query_count_reg != '0) state_next = ST_QREAD;
                        end
                    endcase
                end
            end
            ST_QREAD:
            begin
                // query edges valid now; start rectangle walk
                q_next   = q_edges;
                acc_next = '0;
                ri_next  = '0;
                state_next = (rect_count_reg == '0) ? ST_EMIT : ST_RREAD;
            end
            ST_RREAD:
            begin
                state_next = ST_OVL;
            end
            ST_OVL:
            begin
                ox_next = ovl(r_edges[CW-1:0], r_edges[2*CW-1:CW],
                              q_reg[CW-1:0], q_reg[2*CW-1:CW]);
                oy_next = ovl(r_edges[3*CW-1:2*CW], r_edges[4*CW-1:3*CW],
                              q_reg[3*CW-1:2*CW], q_reg[4*CW-1:3*CW]);
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                prod_next  = SUM_BITS'(mul_p);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                acc_next   = acc_reg + SUM_BITS'(mul_p);
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cross_next = mul_p[MW-1:0];
                state_next = ST_MUL4;
            end
            ST_MUL4:
            begin
                acc_next = acc_reg + SUM_BITS'({cross_sum, {MW{1'b0}}});
                ri_next  = ri_reg + 1'b1;
                state_next = (ri_reg + 1'b1 == rect_count_reg) ? ST_EMIT : ST_RREAD;
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    qi_next = qi_reg + 1'b1;
                    state_next = (qi_reg + 1'b1 == query_count_reg) ? ST_IDLE : ST_QREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output channel
    assign out_ch.valid       = (state_reg == ST_EMIT);
    assign out_ch.query_index = QIDX_W'(qi_reg);
    assign out_ch.sum         = WEIGHT_W'($signed(acc_reg));
    assign out_ch.last        = (qi_reg + 1'b1 == query_count_reg);
    assign out_ch.overflow    = dropped_reg;

    `ORS_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE, !in_ch.ready,
        "input ready while run in progress")
    `ORS_ASSERT_IMP(a_emit_in_range, clk, rst_n, out_ch.valid, qi_reg < query_count_reg,
        "answer index beyond stored queries")
    `ORS_ASSERT_NEXT(a_last_ends_run, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.last,
        state_reg == ST_IDLE, "run did not end after last answer")
endmodule

@@ tb/tb_offline_rect_add_rect_sum_top.sv @@
// Self-checking testbench for offline_rect_add_rect_sum_top: a directed table,
// a table-full segment, then random add/query/run/clear transactions checked against a software sweep.
// Depends on ors_pkg, ors_in_if and ors_out_if.
module tb_offline_rect_add_rect_sum_top;
    import ors_pkg::*;

    typedef struct {
        cmd_t              cmd;
        logic signed [31:0] xl;
        logic signed [31:0] xh;
        logic signed [31:0] yl;
        logic signed [31:0] yh;
        logic signed [63:0] w;
        bit                 typed;
        logic signed [63:0] tsum;
    } stim_t;

    typedef struct {
        logic [QIDX_W-1:0]  idx;
        logic signed [63:0] sum;
        logic               last;
        logic               ovf;
    } answer_t;

    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 400;

    logic clk;
    logic rst_n;
    ors_in_if  in_ch ();
    ors_out_if out_ch ();

    offline_rect_add_rect_sum_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow tables
    longint rx0 [MAX_RECTS_DEF];
    longint rx1 [MAX_RECTS_DEF];
    longint ry0 [MAX_RECTS_DEF];
    longint ry1 [MAX_RECTS_DEF];
    longint unsigned rwt [MAX_RECTS_DEF];
    longint qx0 [MAX_QUERIES_DEF];
    longint qx1 [MAX_QUERIES_DEF];
    longint qy0 [MAX_QUERIES_DEF];
    longint qy1 [MAX_QUERIES_DEF];
    int  n_rects;
    int  n_queries;
    bit  dropped;

    answer_t pending_answers [$];
    int      errors = 0;
    int      cycle_cnt = 0;
    int      src_idle_pct;
    int      snk_idle_pct;
    int      hold_len;
    bit      hold_req = 1'b0;
    bit      hold_seen;
    stim_t   directed [$];

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Timeout
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("tb_offline_rect_add_rect_sum_top failed");
            $finish;
        end
    end

    // Receiver: random stalls plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_len     <= 0;
            hold_seen    <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            out_ch.ready <= 1'b0;
            hold_seen    <= hold_req;
            hold_len     <= HOLD_CYCLES - 1;
        end
        else if (hold_len > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_len     <= hold_len - 1;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected answer idx=%0d sum=%0h", $time,
                         out_ch.query_index, out_ch.sum);
                errors++;
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                if (out_ch.query_index !== exp_a.idx || out_ch.sum !== exp_a.sum ||
                    out_ch.last !== exp_a.last || out_ch.overflow !== exp_a.ovf)
                begin
                    $display("%0t: mismatch exp idx=%0d sum=%0h last=%0b ovf=%0b", $time,
                             exp_a.idx, exp_a.sum, exp_a.last, exp_a.ovf);
                    $display("%0t:          act idx=%0d sum=%0h last=%0b ovf=%0b", $time,
                             out_ch.query_index, out_ch.sum, out_ch.last, out_ch.overflow);
                    errors++;
                end
            end
        end
    end

    function automatic longint unsigned overlap_len(longint a0, longint a1,
                                                    longint b0, longint b1);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? longint'(hi - lo) : 64'd0;
    endfunction

    // Apply one accepted transaction to the shadow tables; run queues answers
    task automatic apply_transaction(stim_t s);
        longint a0, a1, b0, b1;
        longint unsigned acc;
        answer_t a;
        a0 = s.xl; a1 = s.xh; b0 = s.yl; b1 = s.yh;
        case (s.cmd)
            CMD_ADD:
            begin
                if (a0 > a1 || b0 > b1 || n_rects >= MAX_RECTS_DEF)
                    dropped = 1'b1;
                else
                begin
                    rx0[n_rects] = a0; rx1[n_rects] = a1;
                    ry0[n_rects] = b0; ry1[n_rects] = b1;
                    rwt[n_rects] = s.w;
                    n_rects++;
                end
            end
            CMD_QUERY:
            begin
                if (a0 > a1 || b0 > b1 || n_queries >= MAX_QUERIES_DEF)
                    dropped = 1'b1;
                else
                begin
                    qx0[n_queries] = a0; qx1[n_queries] = a1;
                    qy0[n_queries] = b0; qy1[n_queries] = b1;
                    n_queries++;
                end
            end
            CMD_CLEAR:
            begin
                n_rects   = 0;
                n_queries = 0;
                dropped   = 1'b0;
            end
            default:
            begin
                for (int k = 0; k < n_queries; k++)
                begin
                    acc = 0;
                    for (int i = 0; i < n_rects; i++)
                        acc += overlap_len(rx0[i], rx1[i], qx0[k], qx1[k]) *
                               overlap_len(ry0[i], ry1[i], qy0[k], qy1[k]) * rwt[i];
                    a.idx  = k[QIDX_W-1:0];
                    a.sum  = acc;
                    a.last = (k + 1 == n_queries);
                    a.ovf  = dropped;
                    // typed-in answer replaces the final one of the run
                    if (s.typed && a.last)
                        a.sum = s.tsum;
                    pending_answers.insert(pending_answers.size(), a);
                end
            end
        endcase
    endtask

    // Offer one transaction and wait for acceptance
    task automatic send(stim_t s);
        int gap;
        if ($urandom_range(99) < src_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= s.cmd;
        in_ch.x_low   <= s.xl;
        in_ch.x_high  <= s.xh;
        in_ch.y_low   <= s.yl;
        in_ch.y_high  <= s.yh;
        in_ch.weight  <= s.w;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        apply_transaction(s);
    endtask

    function automatic stim_t mk(cmd_t c, longint xl, longint xh, longint yl, longint yh,
                                 logic signed [63:0] w, bit typed, logic signed [63:0] ts);
        stim_t s;
        s.cmd = c; s.xl = xl; s.xh = xh; s.yl = yl; s.yh = yh;
        s.w = w; s.typed = typed; s.tsum = ts;
        return s;
    endfunction

    // Append one row to the directed table
    function automatic void append_row(stim_t s);
        directed.insert(directed.size(), s);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $signed($urandom_range(16)) - 8;
        else if (r < 85)
            return (r[0]) ? 32'sh7FFFFFFF : 32'sh80000000;
        return $urandom;
    endfunction

    // Random add or query, mostly well formed
    function automatic stim_t rand_box(cmd_t c);
        stim_t s;
        logic signed [31:0] t;
        s = mk(c, 0, 0, 0, 0, {$urandom, $urandom}, 1'b0, 0);
        s.xl = rand_coord(); s.xh = rand_coord();
        s.yl = rand_coord(); s.yh = rand_coord();
        if ($urandom_range(99) < 85)
        begin
            if (s.xl > s.xh) begin t = s.xl; s.xl = s.xh; s.xh = t; end
            if (s.yl > s.yh) begin t = s.yl; s.yl = s.yh; s.yh = t; end
        end
        if ($urandom_range(3) == 0)
            s.w = $signed($urandom_range(20)) - 10;
        return s;
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        int items;
        int nr;
        int nq;
        int nt;
        stim_t s;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        n_rects      = 0;
        n_queries    = 0;
        dropped      = 1'b0;
        rst_n        = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_ADD;
        in_ch.x_low   = '0;
        in_ch.x_high  = '0;
        in_ch.y_low   = '0;
        in_ch.y_high  = '0;
        in_ch.weight  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        append_row(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b0, 0));   // run with no queries
        append_row(mk(CMD_ADD, 0, 2, 0, 3, 5, 1'b0, 0));
        append_row(mk(CMD_QUERY, 0, 2, 0, 3, 0, 1'b0, 0));
        append_row(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b1, 30));
        append_row(mk(CMD_ADD, 3, 1, 0, 1, 7, 1'b0, 0));   // inverted x
        append_row(mk(CMD_QUERY, -1, 1, 1, 5, 0, 1'b0, 0));
        append_row(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b1, 10));  // repeated run
        append_row(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 1'b0, 0));
        append_row(mk(CMD_ADD, -64'sd2147483648, 2147483647, 0, 1, 1, 1'b0, 0));
        append_row(mk(CMD_QUERY, -64'sd2147483648, 2147483647,
                      -64'sd2147483648, 2147483647, 0, 1'b0, 0));
        append_row(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b1, 64'hFFFFFFFF));
        append_row(mk(CMD_ADD, 5, 5, 0, 4, 64'sh7FFFFFFFFFFFFFFF, 1'b0, 0));
        append_row(mk(CMD_ADD, 0, 1, 0, 1, 64'sh8000000000000000, 1'b0, 0));
        append_row(mk(CMD_QUERY, 0, 1, 0, 1, 0, 1'b0, 0));
        append_row(mk(CMD_QUERY, 0, 1, 4, 2, 0, 1'b0, 0)); // inverted y
        append_row(mk(CMD_ADD, -5, -1, -5, -1, -3, 1'b0, 0));
        append_row(mk(CMD_QUERY, -8, 8, -8, 8, 0, 1'b0, 0));
        append_row(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b0, 0));
        append_row(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 1'b0, 0));
        append_row(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b0, 0));
        append_row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 1'b0, 0));
        append_row(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b1, 0));
        foreach (directed[i])
            send(directed[i]);

        // Table-full segment under a long receiver hold-off
        drain();
        send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 1'b0, 0));
        for (int i = 0; i < MAX_RECTS_DEF + 2; i++)
            send(rand_box(CMD_ADD));
        for (int i = 0; i < MAX_QUERIES_DEF + 2; i++)
            send(rand_box(CMD_QUERY));
        hold_req = ~hold_req;
        send(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b0, 0));
        send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 1'b0, 0));
        send(mk(CMD_QUERY, 1, 2, 1, 2, 0, 1'b0, 0));
        send(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b0, 0));
        drain();

        // Random segments, cycling through the idling phases
        items = 0;
        for (int seg = 0; items < 200; seg++)
        begin
            case (seg % 4)
                0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
                1: begin src_idle_pct = 67; snk_idle_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_idle_pct = 67; end
                default: begin src_idle_pct = 35; snk_idle_pct = 35; end
            endcase
            if ($urandom_range(2) != 0)
            begin
                send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 1'b0, 0));
                items++;
            end
            nr = $urandom_range(0, 6);
            nq = $urandom_range(0, 6);
            nt = nr + nq;
            for (int i = 0; i < nt; i++)
            begin
                s = rand_box((i % 2 == 0 && nr > 0 || nq == 0) ? CMD_ADD : CMD_QUERY);
                if (s.cmd == CMD_ADD) nr--; else nq--;
                send(s);
                items++;
            end
            send(mk(CMD_RUN, 0, 0, 0, 0, 0, 1'b0, 0));
            items++;
            if (seg % 5 == 4)
                drain();
        end

        drain();
        if (errors == 0)
            $display("tb_offline_rect_add_rect_sum_top passed");
        else
            $display("tb_offline_rect_add_rect_sum_top failed");
        $finish;
    end
endmodule
